// ===== rtl/core/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int PIXEL_MAX      = 255;
    localparam int PIX_W          = 24;
    localparam int COEF_W         = 16;
    localparam int KROW_W         = 48;
    localparam int TAPS           = 9;
    localparam int CFG_ADDR_W     = 3;
    localparam int IMG_W_W        = 13;
    localparam int IMG_H_W        = 16;

    localparam logic [KROW_W-1:0] KERN_TOP_RST = 48'd0;
    localparam logic [KROW_W-1:0] KERN_MID_RST = 48'd16777216;
    localparam logic [KROW_W-1:0] KERN_BOT_RST = 48'd0;
    localparam logic [IMG_W_W-1:0] IMG_W_RST   = 13'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RST   = 16'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KERN_TOP = 3'd0,
        CFG_KERN_MID = 3'd1,
        CFG_KERN_BOT = 3'd2,
        CFG_IMG_W    = 3'd3,
        CFG_IMG_H    = 3'd4
    } t_cfg_idx;

    typedef logic [7:0]        t_chan;
    typedef logic [COEF_W-1:0] t_coef;

endpackage

// ===== rtl/core/rgbc_line_mem.sv =====
module rgbc_line_mem #(
    parameter int DEPTH = 4096,
    parameter int DW    = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rgbc_lane.sv =====
module rgbc_lane #(
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  rgbc_pkg::t_chan     i_px   [rgbc_pkg::TAPS],
    input  rgbc_pkg::t_coef     i_coef [rgbc_pkg::TAPS],
    output rgbc_pkg::t_chan     o_pix
);
    import rgbc_pkg::*;

    localparam int PW = 8 + 1 + COEF_W;
    localparam int SW = PW + 4;

    logic signed [PW-1:0] r_prod [TAPS];
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    t_chan                n_pix;
    t_chan                r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= PW'($signed({1'b0, i_px[k]}) * $signed(i_coef[k]));
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            sum = sum + SW'(r_prod[k]);
        end
        shifted = sum >>> FRAC_BITS;
        if (sum < 0) begin
            n_pix = '0;
        end else if (shifted > SW'(PIXEL_MAX)) begin
            n_pix = t_chan'(PIXEL_MAX);
        end else begin
            n_pix = shifted[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// ===== rtl/core/rgb_image_convolution_3x3.sv =====
// pipeline: the window that an input beat completes passes r_snap, the lane products and the lane result
// throughput: one beat per cycle in and out while i_ready does not stall the output; o_ready waits
// after reset or a width change while the line store prefetch catches up
// reset: synchronous active low; clears counters, tap window, pipeline valids and
// loads the default kernel and image size; the line store is not cleared
module rgb_image_convolution_3x3 #(
    parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = rgbc_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rgbc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rgbc_pkg::KROW_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_pixel_red,
    input  logic [7:0]                      i_pixel_green,
    input  logic [7:0]                      i_pixel_blue,
    input  logic                            i_flush,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic                            o_frame_last
);
    import rgbc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = IMG_H_W + 1;

    logic [KROW_W-1:0]  r_kern [3];
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;

    logic [CW-1:0]      r_in_col;
    logic [RW-1:0]      r_in_row;
    logic [CW-1:0]      r_out_col;
    logic [IMG_H_W-1:0] r_out_row;
    logic [PIX_W-1:0]   r_win [TAPS];

    logic [CW-1:0]      r_rd_addr;
    logic               r_rd_ok;
    logic               r_byp;
    logic [2*PIX_W-1:0] r_byp_data;
    logic [2*PIX_W-1:0] mem_rdata;
    logic [2*PIX_W-1:0] rd;

    logic [PIX_W-1:0]   r_snap [TAPS];
    logic               r_v1, r_v2, r_v3;
    logic               r_l1, r_l2, r_l3;

    logic [WW-1:0]      eff_w;
    logic [IMG_H_W-1:0] eff_h;
    logic               in_wrap, out_wrap;
    logic [CW-1:0]      ix, ox;
    logic [RW-1:0]      iy;
    logic [IMG_H_W-1:0] oy;
    logic               draining, ignore, emit, last, en, acc;
    logic [PIX_W-1:0]   top, mid, bot;
    logic [PIX_W-1:0]   n_win [TAPS];
    logic [PIX_W-1:0]   snap [TAPS];
    logic [CW:0]        c1;
    logic [CW-1:0]      n_in_col, n_out_col, raddr;
    logic [RW-1:0]      n_in_row;
    logic [IMG_H_W-1:0] n_out_row;
    t_coef              coef [TAPS];
    t_chan              lane_px [3][TAPS];
    t_chan              lane_out [3];

    always_comb begin
        if (r_img_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_img_w);
        end
        eff_h = (r_img_h == '0) ? IMG_H_W'(1) : r_img_h;

        in_wrap  = 32'(r_in_col) >= 32'(eff_w);
        ix       = in_wrap ? '0 : r_in_col;
        iy       = in_wrap ? r_in_row + RW'(1) : r_in_row;
        out_wrap = 32'(r_out_col) >= 32'(eff_w);
        ox       = out_wrap ? '0 : r_out_col;
        oy       = out_wrap ? r_out_row + IMG_H_W'(1) : r_out_row;

        draining = 32'(iy) >= 32'(eff_h);
        ignore   = i_flush && !draining;
        emit     = !ignore && (((ix == '0) && (iy >= RW'(2)))
                              || ((ix != '0) && (iy >= RW'(1))));
        last     = emit && (32'(oy) >= 32'(eff_h) - 32'd1)
                        && (32'(ox) >= 32'(eff_w) - 32'd1);

        en      = !r_v3 || i_ready;
        o_ready = en && r_rd_ok && (r_rd_addr == ix);
        acc     = i_valid && o_ready;

        rd  = r_byp ? r_byp_data : mem_rdata;
        top = (iy >= RW'(2)) ? rd[2*PIX_W-1:PIX_W] : '0;
        mid = (iy >= RW'(1)) ? rd[PIX_W-1:0] : '0;
        bot = draining ? '0 : {i_pixel_blue, i_pixel_green, i_pixel_red};

        for (int r = 0; r < 3; r++) begin
            snap[r*3+0] = r_win[r*3+1];
            snap[r*3+1] = r_win[r*3+2];
            snap[r*3+2] = '0;
            n_win[r*3+0] = (ix == '0) ? '0 : r_win[r*3+1];
            n_win[r*3+1] = (ix == '0) ? '0 : r_win[r*3+2];
        end
        n_win[2] = top;
        n_win[5] = mid;
        n_win[8] = bot;
        if (ix != '0) begin
            snap = n_win;
        end

        c1 = {1'b0, ix} + (CW+1)'(1);
        if (last) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (ignore) begin
            n_in_col = ix;
            n_in_row = iy;
        end else if (32'(c1) >= 32'(eff_w)) begin
            n_in_col = '0;
            n_in_row = iy + RW'(1);
        end else begin
            n_in_col = c1[CW-1:0];
            n_in_row = iy;
        end

        n_out_col = ox;
        n_out_row = oy;
        if (last) begin
            n_out_col = '0;
            n_out_row = '0;
        end else if (emit) begin
            if (32'(ox) + 32'd1 >= 32'(eff_w)) begin
                n_out_col = '0;
                n_out_row = oy + IMG_H_W'(1);
            end else begin
                n_out_col = ox + CW'(1);
            end
        end

        raddr = acc ? n_in_col : ix;

        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = r_kern[r][16*c +: 16];
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < TAPS; k++) begin
                lane_px[ch][k] = r_snap[k][8*ch +: 8];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern[0] <= KERN_TOP_RST;
            r_kern[1] <= KERN_MID_RST;
            r_kern[2] <= KERN_BOT_RST;
            r_img_w   <= IMG_W_RST;
            r_img_h   <= IMG_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KERN_TOP: r_kern[0] <= i_cfg_data;
                CFG_KERN_MID: r_kern[1] <= i_cfg_data;
                CFG_KERN_BOT: r_kern[2] <= i_cfg_data;
                CFG_IMG_W:    r_img_w   <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMG_H:    r_img_h   <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters, window and prefetch control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_rd_ok   <= 1'b0;
            r_byp     <= 1'b0;
            r_rd_addr <= '0;
            for (int k = 0; k < TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_rd_ok   <= 1'b1;
            r_rd_addr <= raddr;
            r_byp     <= acc && !ignore && (n_in_col == ix);
            if (acc) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
                if (!ignore) begin
                    r_win <= n_win;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= {rd[PIX_W-1:0], bot};
    end

    rgbc_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (2*PIX_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (acc && !ignore),
        .i_waddr (ix),
        .i_wdata ({rd[PIX_W-1:0], bot}),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    // result pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= acc && emit;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1   <= last;
            r_l2   <= r_l1;
            r_l3   <= r_l2;
            r_snap <= snap;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rgbc_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_px   (lane_px[ch]),
            .i_coef (coef),
            .o_pix  (lane_out[ch])
        );
    end

    assign o_valid      = r_v3;
    assign o_frame_last = r_l3;
    assign o_out_red    = lane_out[0];
    assign o_out_green  = lane_out[1];
    assign o_out_blue   = lane_out[2];

endmodule

// ===== dv/rgb_image_convolution_3x3_tb.sv =====
`timescale 1ns / 1ps

module rgb_image_convolution_3x3_tb;
    import rgbc_pkg::*;

    localparam int LINE_DEPTH = 4096;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  last;
    } t_filtered_px;

    class conv_scoreboard;
        logic [KROW_W-1:0]  krow[3];
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        logic [PIX_W-1:0]   lines[2*LINE_DEPTH];
        logic [PIX_W-1:0]   win[TAPS];
        int unsigned        in_col, in_row, out_col, out_row;
        t_filtered_px       pending[$];
        int                 errors;

        function new();
            krow[0] = KERN_TOP_RST;
            krow[1] = KERN_MID_RST;
            krow[2] = KERN_BOT_RST;
            width_reg = IMG_W_RST;
            height_reg = IMG_H_RST;
            foreach (lines[i]) lines[i] = '0;
            foreach (win[i]) win[i] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [KROW_W-1:0] v);
            case (idx)
                CFG_KERN_TOP: krow[0] = v;
                CFG_KERN_MID: krow[1] = v;
                CFG_KERN_BOT: krow[2] = v;
                CFG_IMG_W:    width_reg = v[IMG_W_W-1:0];
                CFG_IMG_H:    height_reg = v[IMG_H_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function bit frame_open();
            return in_col != 0 || in_row != 0;
        endfunction

        function void shift_col(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                logic [PIX_W-1:0] b);
            logic [PIX_W-1:0] c[3];
            c[0] = t; c[1] = m; c[2] = b;
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
                win[r*3+2] = c[r];
            end
        endfunction

        function t_chan filter_chan(int sh);
            int acc;
            logic signed [COEF_W-1:0] cf;
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) begin
                    cf = krow[r][16*c +: 16];
                    acc += int'(win[r*3+c][sh +: 8]) * int'(cf);
                end
            if (acc < 0) return 8'd0;
            acc = acc >>> FRAC_BITS_DEF;
            return (acc > PIXEL_MAX) ? 8'(PIXEL_MAX) : 8'(acc);
        endfunction

        function bit emit_px(int unsigned w, int unsigned h);
            t_filtered_px px;
            px.last  = (out_row >= h - 1) && (out_col >= w - 1);
            px.red   = filter_chan(0);
            px.green = filter_chan(8);
            px.blue  = filter_chan(16);
            pending.push_back(px);
            if (!px.last) begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
            return px.last;
        endfunction

        function void note_beat(t_chan r, t_chan g, t_chan b, logic fl);
            int unsigned w, h, ix, iy;
            bit drain, last, got;
            logic [PIX_W-1:0] t, m, bt;
            w = eff_w(); h = eff_h();
            last = 0; got = 0;
            if (in_col >= w) begin in_col = 0; in_row++; end
            if (out_col >= w) begin out_col = 0; out_row++; end
            drain = in_row >= h;
            if (fl && !drain) return;
            ix = in_col; iy = in_row;
            if (ix == 0) begin
                if (iy >= 2) begin
                    shift_col('0, '0, '0);
                    last = emit_px(w, h);
                    got = 1;
                end
                foreach (win[i]) win[i] = '0;
            end
            t  = (iy >= 2) ? lines[LINE_DEPTH + ix] : '0;
            m  = (iy >= 1) ? lines[ix] : '0;
            bt = drain ? '0 : {b, g, r};
            lines[LINE_DEPTH + ix] = lines[ix];
            lines[ix] = bt;
            shift_col(t, m, bt);
            if (!got && ix >= 1 && iy >= 1) last = emit_px(w, h);
            if (last) begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end else begin
                in_col++;
                if (in_col >= w) begin in_col = 0; in_row++; end
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_beat(t_chan r, t_chan g, t_chan b, logic last);
            t_filtered_px want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat %h %h %h last %b", r, g, b, last));
                return;
            end
            want = pending.pop_front();
            if (r !== want.red)
                report($sformatf("red got %h want %h", r, want.red));
            if (g !== want.green)
                report($sformatf("green got %h want %h", g, want.green));
            if (b !== want.blue)
                report($sformatf("blue got %h want %h", b, want.blue));
            if (last !== want.last)
                report($sformatf("frame_last got %b want %b", last, want.last));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [KROW_W-1:0]     i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [7:0]            i_pixel_red, i_pixel_green, i_pixel_blue;
    logic                  i_flush;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_out_red, o_out_green, o_out_blue;
    logic                  o_frame_last;

    conv_scoreboard sb;
    bit     calm;
    longint cycles = 0;
    int     beats_sent;

    rgb_image_convolution_3x3 u_dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rgb_image_convolution_3x3_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_beat(o_out_red, o_out_green, o_out_blue, o_frame_last);
    end

    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            n = $urandom_range(1, 30);
            repeat (n) @(negedge i_clk) i_ready <= 1'b1;
            if (!calm) begin
                n = $urandom_range(1, 19);
                repeat (n) @(negedge i_clk) i_ready <= 1'b0;
            end
        end
    end

    task automatic send_beat(t_chan r, t_chan g, t_chan b, logic fl);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_pixel_red   <= r;
        i_pixel_green <= g;
        i_pixel_blue  <= b;
        i_flush       <= fl;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        sb.note_beat(r, g, b, fl);
        beats_sent++;
    endtask

    task automatic send_rand(logic fl);
        send_beat(8'($urandom), 8'($urandom), 8'($urandom), fl);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [KROW_W-1:0] v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.frame_open() || sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_valid    <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [KROW_W-1:0] rand_krow(int mode);
        logic [KROW_W-1:0] k;
        int v;
        for (int c = 0; c < 3; c++) begin
            v = $urandom_range(0, 200) - 60;
            k[16*c +: 16] = (mode == 0) ? 16'($urandom) : 16'(v);
        end
        return k;
    endfunction

    // pixels of one frame with stray flushes at the noise rate, then mostly flushes until the frame closes
    task automatic run_frame(int noise);
        int unsigned npix;
        npix = sb.eff_w() * sb.eff_h();
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(0, 99) < noise) send_rand(1'b1);
            send_rand(1'b0);
        end
        while (sb.frame_open())
            send_rand(($urandom_range(0, 99) < noise) ? 1'b0 : 1'b1);
    endtask

    initial begin
        int mode;
        sb = new();
        calm = 0;
        beats_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel_red = '0;
        i_pixel_green = '0;
        i_pixel_blue = '0;
        i_flush = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 3x2 frame, identity kernel, extreme pixels, stray flush and drain pixel
        write_cfg(CFG_IMG_W, 48'd3);
        write_cfg(CFG_IMG_H, 48'd2);
        send_beat(8'h00, 8'hff, 8'h00, 1'b1);
        send_beat(8'hff, 8'hff, 8'hff, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'hff, 8'h00, 8'h80, 1'b0);
        send_beat(8'h01, 8'hfe, 8'h7f, 1'b1);
        send_beat(8'h55, 8'haa, 8'hff, 1'b0);
        send_beat(8'hff, 8'hff, 8'hff, 1'b0);
        send_beat(8'h00, 8'h01, 8'h02, 1'b0);
        send_beat(8'hff, 8'hff, 8'hff, 1'b0);
        while (sb.frame_open()) send_beat(8'h00, 8'h00, 8'h00, 1'b1);

        // 1x1 via zero size, extreme coefficients
        write_cfg(CFG_KERN_TOP, 48'h8000_7fff_8000);
        write_cfg(CFG_KERN_MID, 48'h7fff_ffff_0001);
        write_cfg(CFG_KERN_BOT, 48'hffff_ffff_ffff);
        write_cfg(CFG_IMG_W, 48'd0);
        write_cfg(CFG_IMG_H, 48'd0);
        send_beat(8'hff, 8'hff, 8'hff, 1'b0);
        while (sb.frame_open()) send_beat(8'hff, 8'hff, 8'hff, 1'b0);
        write_cfg(CFG_KERN_MID, 48'h0000_0100_0000);
        write_cfg(CFG_IMG_W, 48'd2);
        write_cfg(CFG_IMG_H, 48'd3);
        run_frame(0);

        while (beats_sent < 1300) begin
            if ($urandom_range(0, 2) == 0) begin
                mode = $urandom_range(0, 3);
                write_cfg(CFG_KERN_TOP, rand_krow(mode));
                write_cfg(CFG_KERN_MID, rand_krow(mode));
                write_cfg(CFG_KERN_BOT, rand_krow(mode));
            end
            write_cfg(CFG_IMG_W, 48'($urandom_range(1, 9)));
            write_cfg(CFG_IMG_H, 48'($urandom_range(1, 7)));
            repeat ($urandom_range(1, 3)) run_frame(($urandom_range(0, 3) == 0) ? 15 : 0);
        end

        calm = 1;
        write_cfg(CFG_KERN_TOP, rand_krow(1));
        write_cfg(CFG_KERN_BOT, rand_krow(1));
        write_cfg(CFG_IMG_W, 48'd1);
        write_cfg(CFG_IMG_H, 48'd6);
        run_frame(0);
        write_cfg(CFG_IMG_W, 48'd5);
        write_cfg(CFG_IMG_H, 48'd4);
        run_frame(0);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("rgb_image_convolution_3x3_tb passed");
        end else begin
            $display("rgb_image_convolution_3x3_tb failed");
        end
        $finish;
    end

endmodule
